FILE: rtl/lcdnp_pkg.sv
// Shared types and constants for the LCD decimal print block.
`default_nettype none
package lcdnp_pkg;

  localparam int MAX_DIGITS_DEF = 5;

  // Cursor commands and ASCII codes.
  localparam logic [7:0] CMD_HOME   = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'h80;
  localparam logic [7:0] LINE2_BASE = 8'hc0;
  localparam logic [7:0] LINE3_BASE = 8'h94;
  localparam logic [7:0] LINE4_BASE = 8'hd4;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_E    = 8'h45;

  // q = (v * RECIP_10) >> RECIP_SHIFT is floor(v / 10) for every 32-bit v.
  localparam logic [31:0] RECIP_10    = 32'hcccccccd;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic [7:0]  row;
    logic [4:0]  column;
    logic [31:0] value;
    logic [3:0]  digit_count;
  } num_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       last;
  } lcd_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic       has_cmd;
    logic [7:0] cmd_byte;
    logic       is_err;
    logic [3:0] ndig;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef enum logic {
    FRONT_IDLE,
    FRONT_CONV
  } front_state_t;

endpackage
`default_nettype wire

FILE: rtl/lcdnp_front.sv
// Front end: accept an item, classify it and extract its decimal digits.
`default_nettype none
module lcdnp_front #(
  parameter int MAX_DIGITS = lcdnp_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    num_valid,
  output logic                         num_stall,
  input  wire lcdnp_pkg::num_t         num,
  output logic                         push,
  output lcdnp_pkg::job_t              push_job,
  output logic [4*MAX_DIGITS-1:0]      push_digits,
  input  wire logic                    q_full
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  lcdnp_pkg::front_state_t state, state_next;
  lcdnp_pkg::job_t         job, job_in;
  logic [31:0]             value;
  logic [CW-1:0]           remain, remain_in;
  logic [IW-1:0]           idx;
  logic [4*MAX_DIGITS-1:0] digits;

  logic        done, has_any, free, accept;
  logic [63:0] prod;
  logic [31:0] quot, rem_full;
  logic [7:0]  base;
  logic        base_ok;

  // Classify the incoming item.
  always_comb begin
    base    = lcdnp_pkg::LINE1_BASE;
    base_ok = 1'b1;
    case (num.row)
      8'd1:    base = lcdnp_pkg::LINE1_BASE;
      8'd2:    base = lcdnp_pkg::LINE2_BASE;
      8'd3:    base = lcdnp_pkg::LINE3_BASE;
      8'd4:    base = lcdnp_pkg::LINE4_BASE;
      default: base_ok = 1'b0;
    endcase

    job_in = '0;
    if (num.row == 8'd0 || num.column == 5'd0) begin
      job_in.has_cmd  = 1'b1;
      job_in.cmd_byte = lcdnp_pkg::CMD_HOME;
    end else if (base_ok) begin
      job_in.has_cmd  = 1'b1;
      job_in.cmd_byte = base + {3'b000, num.column} - 8'd1;
    end

    remain_in = '0;
    if (int'(num.digit_count) > MAX_DIGITS) begin
      job_in.is_err = 1'b1;
    end else begin
      job_in.ndig = num.digit_count;
      remain_in   = CW'(num.digit_count);
    end
  end

  // One divide-by-ten step per cycle, low place first.
  always_comb begin
    prod     = 64'(value) * 64'(lcdnp_pkg::RECIP_10);
    quot     = 32'(prod >> lcdnp_pkg::RECIP_SHIFT);
    rem_full = value - ((quot << 3) + (quot << 1));
  end

  assign done    = (state == lcdnp_pkg::FRONT_CONV) && (remain == '0);
  assign has_any = job.has_cmd || job.is_err || (job.ndig != 4'd0);
  assign free    = (state == lcdnp_pkg::FRONT_IDLE) || (done && (!q_full || !has_any));
  assign accept  = num_valid && free;

  assign num_stall   = !free;
  assign push        = done && has_any && !q_full;
  assign push_job    = job;
  assign push_digits = digits;

  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = lcdnp_pkg::FRONT_CONV;
    end else if (free) begin
      state_next = lcdnp_pkg::FRONT_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdnp_pkg::FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job    <= job_in;
      value  <= num.value;
      remain <= remain_in;
      idx    <= '0;
    end else if (state == lcdnp_pkg::FRONT_CONV && remain != '0) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (idx == IW'(i)) begin
          digits[4*i +: 4] <= rem_full[3:0];
        end
      end
      value  <= quot;
      remain <= remain - CW'(1);
      idx    <= idx + IW'(1);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lcdnp_queue.sv
// Two-entry queue between the front and back ends.
`default_nettype none
module lcdnp_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lcdnp_back.sv
// Back end: walk the head job and emit one LCD byte per beat.
`default_nettype none
module lcdnp_back #(
  parameter int MAX_DIGITS = lcdnp_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    not_empty,
  input  wire lcdnp_pkg::job_t         job,
  input  wire logic [4*MAX_DIGITS-1:0] digits,
  output logic                         pop,
  output logic                         lcd_valid,
  input  wire logic                    lcd_stall,
  output lcdnp_pkg::lcd_t              lcd
);

  logic [3:0] pos, k, di, total, digit;
  logic       is_last, fire;

  always_comb begin
    total   = {3'b000, job.has_cmd} + (job.is_err ? 4'd1 : job.ndig);
    k       = pos - {3'b000, job.has_cmd};
    di      = job.ndig - 4'd1 - k;
    is_last = (pos == total - 4'd1);

    digit = 4'd0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (di == 4'(i)) begin
        digit = digits[4*i +: 4];
      end
    end

    lcd.last       = is_last;
    lcd.is_command = 1'b0;
    if (job.has_cmd && pos == 4'd0) begin
      lcd.out_byte   = job.cmd_byte;
      lcd.is_command = 1'b1;
    end else if (job.is_err) begin
      lcd.out_byte = lcdnp_pkg::ASCII_E;
    end else begin
      lcd.out_byte = lcdnp_pkg::ASCII_ZERO + {4'b0000, digit};
    end
  end

  assign lcd_valid = not_empty;
  assign fire      = lcd_valid && !lcd_stall;
  assign pop       = fire && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
    end else if (fire) begin
      pos <= is_last ? 4'd0 : pos + 4'd1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lcd_decimal_number_print_core.sv
// Top level of the LCD decimal print block: front end, job queue, back end.
// Throughput: the back end sends one byte per cycle while lcd_stall is low; an item
//   has up to 1 + MAX_DIGITS bytes, and the front end's divide-by-ten loop
//   overlaps the back end through the queue.
// Reset: rst clears the front FSM, queue pointers and byte counter; no clearing pass.
`default_nettype none
module lcd_decimal_number_print_core #(
  parameter int MAX_DIGITS = lcdnp_pkg::MAX_DIGITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            num_valid,
  output logic                 num_stall,
  input  wire lcdnp_pkg::num_t num,
  output logic                 lcd_valid,
  input  wire logic            lcd_stall,
  output lcdnp_pkg::lcd_t      lcd
);

  localparam int DW = 4 * MAX_DIGITS;
  localparam int QW = lcdnp_pkg::JOB_W + DW;

  // Front to queue.
  logic            push, q_full;
  lcdnp_pkg::job_t push_job;
  logic [DW-1:0]   push_digits;

  // Queue to back.
  logic            pop, not_empty;
  logic [QW-1:0]   head;
  lcdnp_pkg::job_t head_job;
  logic [DW-1:0]   head_digits;

  // Classify the item and peel off its digits, one per cycle.
  lcdnp_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .num_valid   (num_valid),
    .num_stall   (num_stall),
    .num         (num),
    .push        (push),
    .push_job    (push_job),
    .push_digits (push_digits),
    .q_full      (q_full)
  );

  // Hold finished jobs so the front can take the next beat while bytes drain.
  lcdnp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_job, push_digits}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  assign head_job    = lcdnp_pkg::job_t'(head[QW-1 -: lcdnp_pkg::JOB_W]);
  assign head_digits = head[DW-1:0];

  // Emit the cursor command, if any, then 'E' or the digits most significant first.
  lcdnp_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .job       (head_job),
    .digits    (head_digits),
    .pop       (pop),
    .lcd_valid (lcd_valid),
    .lcd_stall (lcd_stall),
    .lcd       (lcd)
  );

endmodule
`default_nettype wire
